### rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // dividend width: 16-bit byte count plus rounding slack
    localparam int QW = 17;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_INIT0,
        S_IDLE,
        S_DIV,
        S_WALK,
        S_A_DEC,
        S_A_WRB,
        S_F_CHK,
        S_F_CHKN,
        S_F_PREV,
        S_F_CHKP,
        S_F_KILLC,
        S_LNK_RD,
        S_LNK_WR,
        S_FIN
    } t_state;

endpackage

### rtl/core/bfa_div.sv
// ----------------------------------------------------------------------------
// bfa_div
// Division by a constant through a reciprocal multiply, registered result.
// ----------------------------------------------------------------------------
module bfa_div #(
    parameter int DIVISOR = 32,
    localparam int RW = $clog2(DIVISOR) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [bfa_pkg::QW-1:0] i_dividend,
    output logic                  o_done,
    output logic [bfa_pkg::QW-1:0] o_quot,
    output logic [RW-1:0]         o_rem
);
    import bfa_pkg::*;

    // quotient = (x * ceil(2^SH / DIVISOR)) >> SH, exact for any QW-bit x
    localparam int SH = QW + $clog2(DIVISOR);
    localparam int MW = QW + 2;
    localparam int PW = SH + QW;
    localparam logic [MW-1:0] MUL =
        MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PW-1:0] prod;
    logic [QW-1:0] quot;
    logic [QW-1:0] back;
    logic [QW-1:0] rem_full;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quot;
    logic          r_done;

    assign prod     = PW'(i_dividend) * PW'(MUL);
    assign quot     = prod[SH +: QW];
    assign back     = quot * QW'(DIVISOR);
    assign rem_full = i_dividend - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= quot;
            r_rem  <= rem_full[RW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### rtl/core/best_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit allocator over a pool of fixed-size units with block coalescing.
// ----------------------------------------------------------------------------
// Query walks every block header; allocate divides and walks, then on a split
//   writes the remainder and relinks the following block, then writes the grant;
//   free divides, then merges with free neighbours; an unused code goes to the result.
// Throughput: one item at a time, a new one may be taken at the result edge;
//   the header walk reads one header per cycle, so rate follows the block count.
// Reset: synchronous, active low; a clearing pass over every header, then the
//   write of the whole pool as one free block, runs with busy high. Results are
//   strobed for one cycle and cannot be stalled by the receiver.
module best_fit_block_allocator_unit #(
    parameter int POOL_UNITS = 1024,
    parameter int UNIT_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_release_offset,
    output logic        o_done,
    output logic [15:0] o_granted_offset,
    output logic        o_outcome,
    output logic [15:0] o_largest_free_bytes
);
    import bfa_pkg::*;

    localparam int AW = $clog2(POOL_UNITS);     // header index
    localparam int CW = AW + 1;                 // index that may hit the pool end
    localparam int RW = $clog2(UNIT_BYTES) + 1;
    localparam logic [CW-1:0] POOL_C = CW'(POOL_UNITS);

    // one header per unit
    typedef struct packed {
        logic          valid;
        logic          free;
        logic [AW-1:0] size;
        logic [AW-1:0] prev;
        logic          has_prev;
    } t_hdr;

    function automatic logic [CW-1:0] nxt(input logic [AW-1:0] h,
                                          input logic [AW-1:0] s);
        return CW'(h) + CW'(1) + CW'(s);
    endfunction

    // header memory, single port, registered read
    t_hdr          mem [POOL_UNITS];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_hdr          mem_wdata;
    t_hdr          r_rdata;
    logic [AW-1:0] r_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
        r_raddr <= mem_addr;
    end

    // divider for rounding requests and decoding release offsets
    logic          div_start;
    logic [QW-1:0] div_dividend;
    logic          div_done;
    logic [QW-1:0] div_quot;
    logic [RW-1:0] div_rem;

    bfa_div #(.DIVISOR(UNIT_BYTES)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    t_state        r_state, n_state;
    logic [1:0]    r_action, n_action;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_need, n_need;
    logic          r_need_big, n_need_big;
    logic          r_found, n_found;
    logic [AW-1:0] r_best, n_best;
    t_hdr          r_bent, n_bent;
    logic [AW-1:0] r_bsize, n_bsize;
    logic [AW-1:0] r_c, n_c;
    t_hdr          r_ce, n_ce;
    logic [AW-1:0] r_lnk_addr, n_lnk_addr;
    logic [AW-1:0] r_lnk_prev, n_lnk_prev;
    t_state        r_lnk_ret, n_lnk_ret;
    logic          r_lnk_go, n_lnk_go;
    logic          r_grant, n_grant;
    logic          r_nofit, n_nofit;
    logic          r_done;
    logic [15:0]   r_o_granted, r_o_largest;
    logic          r_o_outcome;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // shared datapath terms
    t_hdr          rd;
    logic [CW-1:0] rd_nxt;
    logic          walk_end;
    logic          alloc_fit;
    logic          query_fit;
    logic [AW-1:0] chkn_size;
    logic [CW-1:0] chkn_n2;
    logic [AW-1:0] chkp_size;
    logic [CW-1:0] chkp_n;
    logic [CW-1:0] a_nx;
    logic [AW-1:0] a_rr;
    logic          rel_ok;
    logic          is_alloc;
    logic [31:0]   gprod;
    logic [31:0]   lprod;

    assign rd        = r_rdata;
    assign rd_nxt    = nxt(r_raddr, rd.size);
    assign walk_end  = !rd.valid || (rd_nxt >= POOL_C);
    assign alloc_fit = rd.valid && rd.free && !r_need_big && (rd.size >= r_need)
                       && (!r_found || (rd.size < r_bsize));
    assign query_fit = rd.valid && rd.free && (rd.size > r_bsize);
    assign chkn_size = r_ce.size + AW'(1) + rd.size;
    assign chkn_n2   = nxt(r_c, chkn_size);
    assign chkp_size = rd.size + AW'(1) + r_ce.size;
    assign chkp_n    = nxt(r_raddr, chkp_size);
    assign a_nx      = nxt(r_best, r_bent.size);
    assign a_rr      = r_best + AW'(1) + r_need;
    assign rel_ok    = (div_rem == '0) && (div_quot != '0)
                       && (div_quot <= QW'(POOL_UNITS));
    assign is_alloc  = (r_action == ACT_ALLOC);
    assign gprod     = (32'(r_best) + 32'd1) * 32'(UNIT_BYTES);
    assign lprod     = 32'(r_bsize) * 32'(UNIT_BYTES);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == AW'(POOL_UNITS - 1)) n_state = S_INIT0;
            S_INIT0:  n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_ALLOC, ACT_FREE: n_state = S_DIV;
                        ACT_QUERY:           n_state = S_WALK;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (is_alloc)    n_state = S_WALK;
                    else if (rel_ok) n_state = S_F_CHK;
                    else             n_state = S_FIN;
                end
            end
            S_WALK:   if (walk_end) n_state = is_alloc ? S_A_DEC : S_FIN;
            S_A_DEC: begin
                if (!r_found)                    n_state = S_FIN;
                else if (r_bent.size == r_need)  n_state = S_A_WRB;
                else if (a_nx < POOL_C)          n_state = S_LNK_RD;
                else                             n_state = S_A_WRB;
            end
            S_A_WRB:  n_state = S_FIN;
            S_F_CHK: begin
                if (!rd.valid)              n_state = S_FIN;
                else if (rd_nxt < POOL_C)   n_state = S_F_CHKN;
                else                        n_state = S_F_PREV;
            end
            S_F_CHKN: begin
                if (rd.free && (chkn_n2 < POOL_C)) n_state = S_LNK_RD;
                else                               n_state = S_F_PREV;
            end
            S_F_PREV: n_state = r_ce.has_prev ? S_F_CHKP : S_FIN;
            S_F_CHKP: n_state = (rd.valid && rd.free) ? S_F_KILLC : S_FIN;
            S_F_KILLC: n_state = r_lnk_go ? S_LNK_RD : S_FIN;
            S_LNK_RD: n_state = S_LNK_WR;
            S_LNK_WR: n_state = r_lnk_ret;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory access and working registers
    always_comb begin
        mem_we       = 1'b0;
        mem_addr     = '0;
        mem_wdata    = rd;
        div_start    = 1'b0;
        div_dividend = '0;
        n_action     = r_action;
        n_clr        = r_clr;
        n_need       = r_need;
        n_need_big   = r_need_big;
        n_found      = r_found;
        n_best       = r_best;
        n_bent       = r_bent;
        n_bsize      = r_bsize;
        n_c          = r_c;
        n_ce         = r_ce;
        n_lnk_addr   = r_lnk_addr;
        n_lnk_prev   = r_lnk_prev;
        n_lnk_ret    = r_lnk_ret;
        n_lnk_go     = r_lnk_go;
        n_grant      = r_grant;
        n_nofit      = r_nofit;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            S_INIT0: begin
                // whole pool as one free block
                mem_we         = 1'b1;
                mem_addr       = '0;
                mem_wdata      = '0;
                mem_wdata.valid = 1'b1;
                mem_wdata.free = 1'b1;
                mem_wdata.size = AW'(POOL_UNITS - 1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_found  = 1'b0;
                    n_bsize  = '0;
                    n_grant  = 1'b0;
                    n_nofit  = 1'b0;
                    n_best   = '0;
                    div_start = (i_action == ACT_ALLOC) || (i_action == ACT_FREE);
                    div_dividend = (i_action == ACT_ALLOC)
                        ? (QW'(i_request_bytes) + QW'(UNIT_BYTES - 1))
                        : QW'(i_release_offset);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (is_alloc) begin
                        // zero bytes still take one unit
                        n_need     = (div_quot == '0) ? AW'(1) : div_quot[AW-1:0];
                        n_need_big = (div_quot >= QW'(POOL_UNITS));
                        mem_addr   = '0;
                    end else begin
                        n_c      = AW'(div_quot - QW'(1));
                        mem_addr = AW'(div_quot - QW'(1));
                    end
                end
            end
            S_WALK: begin
                if (is_alloc) begin
                    if (alloc_fit) begin
                        n_found = 1'b1;
                        n_best  = r_raddr;
                        n_bent  = rd;
                        n_bsize = rd.size;
                    end
                end else if (query_fit) begin
                    n_bsize = rd.size;
                end
                mem_addr = rd_nxt[AW-1:0];
            end
            S_A_DEC: begin
                if (!r_found) begin
                    n_nofit = 1'b1;
                end else if (r_bent.size != r_need) begin
                    // split off the remainder as a new free block
                    mem_we             = 1'b1;
                    mem_addr           = a_rr;
                    mem_wdata.valid    = 1'b1;
                    mem_wdata.free     = 1'b1;
                    mem_wdata.size     = r_bent.size - r_need - AW'(1);
                    mem_wdata.prev     = r_best;
                    mem_wdata.has_prev = 1'b1;
                    n_lnk_addr         = a_nx[AW-1:0];
                    n_lnk_prev         = a_rr;
                    n_lnk_ret          = S_A_WRB;
                end
            end
            S_A_WRB: begin
                mem_we         = 1'b1;
                mem_addr       = r_best;
                mem_wdata      = r_bent;
                mem_wdata.free = 1'b0;
                mem_wdata.size = r_need;
                n_grant        = 1'b1;
            end
            S_F_CHK: begin
                n_ce      = rd;
                n_ce.free = 1'b1;
                mem_addr  = rd_nxt[AW-1:0];
            end
            S_F_CHKN: begin
                if (rd.free) begin
                    // absorb the next block
                    n_ce.size       = chkn_size;
                    mem_we          = 1'b1;
                    mem_addr        = r_raddr;
                    mem_wdata.valid = 1'b0;
                    mem_wdata.free  = 1'b0;
                    n_lnk_addr      = chkn_n2[AW-1:0];
                    n_lnk_prev      = r_c;
                    n_lnk_ret       = S_F_PREV;
                end
            end
            S_F_PREV: begin
                if (r_ce.has_prev) begin
                    mem_addr = r_ce.prev;
                end else begin
                    mem_we    = 1'b1;
                    mem_addr  = r_c;
                    mem_wdata = r_ce;
                end
            end
            S_F_CHKP: begin
                mem_we = 1'b1;
                if (rd.valid && rd.free) begin
                    // previous block absorbs this one
                    mem_addr       = r_raddr;
                    mem_wdata.size = chkp_size;
                    n_lnk_addr     = chkp_n[AW-1:0];
                    n_lnk_prev     = r_raddr;
                    n_lnk_ret      = S_FIN;
                    n_lnk_go       = (chkp_n < POOL_C);
                end else begin
                    mem_addr  = r_c;
                    mem_wdata = r_ce;
                end
            end
            S_F_KILLC: begin
                mem_we          = 1'b1;
                mem_addr        = r_c;
                mem_wdata       = r_ce;
                mem_wdata.valid = 1'b0;
                mem_wdata.free  = 1'b0;
            end
            S_LNK_RD: begin
                mem_addr = r_lnk_addr;
            end
            S_LNK_WR: begin
                mem_we             = 1'b1;
                mem_addr           = r_lnk_addr;
                mem_wdata.prev     = r_lnk_prev;
                mem_wdata.has_prev = 1'b1;
            end
            S_FIN: begin
                mem_addr = '0;
            end
            default: begin
                mem_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= (r_state == S_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_need     <= n_need;
        r_need_big <= n_need_big;
        r_found    <= n_found;
        r_best     <= n_best;
        r_bent     <= n_bent;
        r_bsize    <= n_bsize;
        r_c        <= n_c;
        r_ce       <= n_ce;
        r_lnk_addr <= n_lnk_addr;
        r_lnk_prev <= n_lnk_prev;
        r_lnk_ret  <= n_lnk_ret;
        r_lnk_go   <= n_lnk_go;
        r_grant    <= n_grant;
        r_nofit    <= n_nofit;
        if (r_state == S_FIN) begin
            r_o_granted <= r_grant ? gprod[15:0] : 16'd0;
            r_o_outcome <= r_nofit;
            r_o_largest <= (r_action == ACT_QUERY) ? lprod[15:0] : 16'd0;
        end
    end

    assign o_done               = r_done;
    assign o_granted_offset     = r_o_granted;
    assign o_outcome            = r_o_outcome;
    assign o_largest_free_bytes = r_o_largest;

    // result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held");

    // a no-fit result never carries an offset
    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_outcome) |-> (o_granted_offset == 16'd0))
        else $error("offset with no-fit");

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept without busy");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the best-fit block allocator: a directed table of
// requests, then random allocate/free/query traffic with some unused codes, all
// checked against a behavioral copy of the block list kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUNITS    = 1024;
    localparam int UBYTES    = 32;
    localparam int N_RANDOM  = 1530;
    localparam int N_DIRECT  = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [15:0] i_request_bytes;
    logic [15:0] i_release_offset;
    logic        o_done;
    logic [15:0] o_granted_offset;
    logic        o_outcome;
    logic [15:0] o_largest_free_bytes;

    best_fit_block_allocator_unit #(
        .POOL_UNITS(NUNITS),
        .UNIT_BYTES(UBYTES)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_request_bytes     (i_request_bytes),
        .i_release_offset    (i_release_offset),
        .o_done              (o_done),
        .o_granted_offset    (o_granted_offset),
        .o_outcome           (o_outcome),
        .o_largest_free_bytes(o_largest_free_bytes)
    );

    typedef struct packed {
        logic [15:0] granted;
        logic        nofit;
        logic [15:0] largest;
    } t_reply;

    // header list copy: one slot per unit
    bit          blk_valid [NUNITS];
    bit          blk_free  [NUNITS];
    int unsigned blk_units [NUNITS];
    int unsigned blk_prev  [NUNITS];
    bit          blk_hasp  [NUNITS];

    t_reply      pending_replies[$];
    int          errors;
    int          sender_idle_pct;
    // payload offsets currently granted, used to aim frees at live blocks
    logic [15:0] live_offsets[$];

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic int unsigned block_after(int unsigned h);
        int unsigned n;
        n = h + 1 + blk_units[h];
        return (n < NUNITS) ? n : NUNITS;
    endfunction

    function automatic void pool_reset();
        for (int k = 0; k < NUNITS; k++) begin
            blk_valid[k] = 0; blk_free[k] = 0; blk_units[k] = 0;
            blk_prev[k] = 0; blk_hasp[k] = 0;
        end
        blk_valid[0] = 1;
        blk_free[0]  = 1;
        blk_units[0] = NUNITS - 1;
    endfunction

    function automatic t_reply pool_allocate(logic [15:0] bytes);
        t_reply      r;
        int unsigned need, h, best, rem, nx;
        bit          found;
        r = '0;
        need = (int'(bytes) + UBYTES - 1) / UBYTES;
        if (need == 0) need = 1;
        h = 0; best = 0; found = 0;
        while (h < NUNITS && blk_valid[h]) begin
            if (blk_free[h] && blk_units[h] >= need &&
                (!found || blk_units[h] < blk_units[best])) begin
                best = h;
                found = 1;
            end
            h = block_after(h);
        end
        if (!found) begin
            r.nofit = 1'b1;
            return r;
        end
        if (blk_units[best] != need) begin
            rem = best + 1 + need;
            blk_valid[rem] = 1;
            blk_free[rem]  = 1;
            blk_units[rem] = blk_units[best] - need - 1;
            blk_prev[rem]  = best;
            blk_hasp[rem]  = 1;
            nx = block_after(rem);
            if (nx < NUNITS) begin
                blk_prev[nx] = rem;
                blk_hasp[nx] = 1;
            end
            blk_units[best] = need;
        end
        blk_free[best] = 0;
        r.granted = 16'((best + 1) * UBYTES);
        return r;
    endfunction

    function automatic void pool_release(logic [15:0] off);
        int unsigned c, n, p;
        if (off % UBYTES != 0 || off < UBYTES) return;
        if (off / UBYTES - 1 >= NUNITS) return;
        c = off / UBYTES - 1;
        if (!blk_valid[c]) return;
        blk_free[c] = 1;
        n = block_after(c);
        if (n < NUNITS && blk_free[n]) begin
            blk_units[c] += 1 + blk_units[n];
            blk_valid[n] = 0;
            blk_free[n]  = 0;
            n = block_after(c);
            if (n < NUNITS) begin
                blk_prev[n] = c;
                blk_hasp[n] = 1;
            end
        end
        if (blk_hasp[c]) begin
            p = blk_prev[c];
            if (p < NUNITS && blk_valid[p] && blk_free[p]) begin
                blk_units[p] += 1 + blk_units[c];
                blk_valid[c] = 0;
                blk_free[c]  = 0;
                n = block_after(p);
                if (n < NUNITS) begin
                    blk_prev[n] = p;
                    blk_hasp[n] = 1;
                end
            end
        end
    endfunction

    function automatic logic [15:0] pool_largest();
        int unsigned h, best;
        h = 0; best = 0;
        while (h < NUNITS && blk_valid[h]) begin
            if (blk_free[h] && blk_units[h] > best) best = blk_units[h];
            h = block_after(h);
        end
        return 16'(best * UBYTES);
    endfunction

    function automatic t_reply pool_step(logic [1:0] act, logic [15:0] bytes,
                                         logic [15:0] off);
        t_reply r;
        r = '0;
        case (act)
            ACT_ALLOC: r = pool_allocate(bytes);
            ACT_FREE:  pool_release(off);
            ACT_QUERY: r.largest = pool_largest();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // results: compared at the rising edge against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result", o_granted_offset, 16'd0);
            end else begin
                t_reply w;
                w = pending_replies.pop_front();
                if (o_granted_offset !== w.granted)
                    report_mismatch("granted_offset", o_granted_offset, w.granted);
                if (o_outcome !== w.nofit)
                    report_mismatch("outcome", 16'(o_outcome), 16'(w.nofit));
                if (o_largest_free_bytes !== w.largest)
                    report_mismatch("largest_free_bytes", o_largest_free_bytes,
                                    w.largest);
            end
        end
    end

    // one item: optional idle gap, present at the falling edge, hold until taken;
    // start stays up until the next falling edge, where the next item or a gap
    // replaces it
    task automatic issue(logic [1:0] act, logic [15:0] bytes, logic [15:0] off,
                         bit check_typed, t_reply typed);
        t_reply r;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start            <= 1'b1;
        i_action         <= act;
        i_request_bytes  <= bytes;
        i_release_offset <= off;
        do @(posedge i_clk); while (busy);
        r = pool_step(act, bytes, off);
        // values typed into the table must agree with the bench's own copy too
        if (check_typed && r !== typed)
            report_mismatch("table row", r.granted, typed.granted);
        pending_replies.push_back(r);
        if (act == ACT_ALLOC && !r.nofit) live_offsets.push_back(r.granted);
        @(negedge i_clk);
    endtask

    typedef struct {
        logic [1:0]  act;
        logic [15:0] bytes;
        logic [15:0] off;
        bit          typed;
        t_reply      want;
    } t_row;

    t_row direct_rows[N_DIRECT] = '{
        '{ACT_QUERY, 16'd0,     16'd0,     1, '{16'd0,    1'b0, 16'd32736}},
        '{ACT_ALLOC, 16'd0,     16'd0,     1, '{16'd32,   1'b0, 16'd0}},
        '{ACT_ALLOC, 16'd1,     16'hFFFF,  1, '{16'd96,   1'b0, 16'd0}},
        '{ACT_ALLOC, 16'd32768, 16'd0,     1, '{16'd0,    1'b1, 16'd0}},
        '{ACT_ALLOC, 16'hFFFF,  16'd0,     1, '{16'd0,    1'b1, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd33,    1, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd0,     1, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd32768, 1, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd64,    1, '{16'd0,    1'b0, 16'd0}},
        '{2'd3,      16'hFFFF,  16'hFFFF,  1, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd32,    0, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd32,    0, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd96,    0, '{16'd0,    1'b0, 16'd0}},
        '{ACT_ALLOC, 16'd32736, 16'd0,     1, '{16'd32,   1'b0, 16'd0}},
        '{ACT_QUERY, 16'd0,     16'd0,     1, '{16'd0,    1'b0, 16'd0}},
        '{ACT_FREE,  16'd0,     16'd32,    0, '{16'd0,    1'b0, 16'd0}}
    };

    task automatic random_item();
        int          pick;
        int          idx;
        logic [15:0] bytes, off;
        pick = $urandom_range(99);
        bytes = 16'($urandom);
        off = 16'($urandom);
        if (pick < 45) begin
            // mostly small requests keep the list long; a few span the pool
            case ($urandom_range(9))
                0:       bytes = 16'($urandom);
                1:       bytes = 16'($urandom_range(32768, 4096));
                default: bytes = 16'($urandom_range(256, 0));
            endcase
            issue(ACT_ALLOC, bytes, off, 0, '0);
        end else if (pick < 85) begin
            if (live_offsets.size() > 0 && $urandom_range(9) != 0) begin
                idx = $urandom_range(live_offsets.size() - 1);
                off = live_offsets[idx];
                // keep it listed sometimes, so double frees happen
                if ($urandom_range(7) != 0) live_offsets.delete(idx);
            end else if ($urandom_range(1)) begin
                off = 16'($urandom_range(1024, 1) * UBYTES);
            end
            issue(ACT_FREE, bytes, off, 0, '0);
        end else if (pick < 97) begin
            issue(ACT_QUERY, bytes, off, 0, '0);
        end else begin
            issue(2'd3, bytes, off, 0, '0);
        end
    endtask

    // drop start and wait until every result is in
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_replies.size() != 0);
    endtask

    // stimulus
    initial begin
        errors           = 0;
        sender_idle_pct  = 0;
        start            = 1'b0;
        i_action         = ACT_QUERY;
        i_request_bytes  = '0;
        i_release_offset = '0;
        i_rst_n          = 1'b0;
        pool_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (direct_rows[k])
            issue(direct_rows[k].act, direct_rows[k].bytes, direct_rows[k].off,
                  direct_rows[k].typed, direct_rows[k].want);
        live_offsets.delete();

        for (int n = 0; n < N_RANDOM; n++) begin
            // idle profile: busy sender, then light, then none
            if (n < N_RANDOM / 3)           sender_idle_pct = 29;
            else if (n < 2 * N_RANDOM / 3)  sender_idle_pct = 88;
            else                            sender_idle_pct = 0;
            // pause until the result queue runs dry now and then
            if (n % 400 == 200) drain();
            random_item();
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog: covers the header walks of every item plus gaps and clearing
    initial begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_div.sv
rtl/core/best_fit_block_allocator_unit.sv
tb/testbench.sv
